### rtl/rau_pkg.sv
// Shared types and constants of the rational arithmetic unit.
package rau_pkg;

  localparam int unsigned MagW = 64;

  typedef struct packed {
    logic            start;
    logic [MagW-1:0] dividend;
    logic [MagW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [MagW-1:0] quo;
    logic [MagW-1:0] rem;
  } div_res_t;

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;
  localparam logic [2:0] OpAbs = 3'd4;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatZero = 2'd1;
  localparam logic [1:0] StatWide = 2'd2;

endpackage

### rtl/rational_arithmetic_unit.sv
// Top level: sequencer, shared multiplier and gcd datapath of the fraction unit.
//
// One word is taken when start_i is high and busy_o low; busy_o then stays high
// until the result appears for one cycle with done_o, and the receiver must take
// it then. An item goes through four products on the shared multiplier, a step to
// form the raw fraction, one binary gcd step per cycle over 64-bit magnitudes (up to
// about 128 steps), and three or four passes through the bit-serial divider (reduce
// numerator, reduce denominator, integer part, snap bound; the snap bound pass is
// skipped when snap_inverse is zero), then rounding, snap and range check. A zero
// denominator skips from forming the fraction straight to the result. The user must
// write snap_inverse with snap_inverse_we_i only while busy_o is low; the block
// itself does not enforce this.
module rational_arithmetic_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] a_numerator_i,
  input  logic [31:0] a_denominator_i,
  input  logic [31:0] b_numerator_i,
  input  logic [30:0] b_denominator_i,
  input  logic        snap_inverse_we_i,
  input  logic [31:0] snap_inverse_i,
  output logic        done_o,
  output logic [31:0] result_numerator_o,
  output logic [30:0] result_denominator_o,
  output logic        a_less_o,
  output logic        a_greater_o,
  output logic        a_equal_o,
  output logic [1:0]  status_o
);
  import rau_pkg::*;

  localparam logic [MagW-1:0] Lim    = (64'd1 << (WORD_BITS - 1)) - 64'd1;
  localparam logic [MagW-1:0] LimNeg = Lim + 64'd1;

  typedef enum logic [3:0] {
    StIdle, StMulL, StMulR, StMulD, StMulN, StForm, StGcd,
    StDivN, StDivD, StDivQ, StDivS, StRound, StSnap, StDone
  } state_e;

  state_e state_q;

  logic [31:0] snap_q;
  logic [2:0]  op_q;
  logic [31:0] an_q, ad_q, bn_q;
  logic [30:0] bd_q;
  logic [63:0] left_q, right_q, dd_q, nn_q;
  logic        num_neg_q, den_neg_q, rneg_q, err_q;
  logic [MagW-1:0] num_q, den_q, u_q, v_q, g_q;
  logic [5:0]      k_q;
  logic [MagW-1:0] n_q, d_q, q_q, r_q, t_q, near_q, dist_q;
  logic            go_q;
  logic [MagW-1:0] dvd_q, dvs_q;
  logic            done_q;

  div_req_t div_req;
  div_res_t div_res;

  assign div_req = '{start: go_q, dividend: dvd_q, divisor: dvs_q};

  rau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [32:0] an_x, ad_x, bn_x, bd_x;

  assign an_x = $signed({an_q[31], an_q});
  assign ad_x = $signed({ad_q[31], ad_q});
  assign bn_x = $signed({bn_q[31], bn_q});
  assign bd_x = $signed({2'b00, bd_q});

  always_comb begin
    unique case (state_q)
      StMulL:  begin mul_a = an_x; mul_b = bd_x; end
      StMulR:  begin mul_a = bn_x; mul_b = ad_x; end
      StMulD:  begin mul_a = ad_x; mul_b = bd_x; end
      default: begin mul_a = an_x; mul_b = bn_x; end
    endcase
  end

  assign prod = mul_a * mul_b;

  // raw numerator and denominator
  logic signed [65:0] lx, rx, dx, nx, ax, num_s, den_s;
  logic [65:0]        num_abs, den_abs;

  assign lx = $signed({{2{left_q[63]}}, left_q});
  assign rx = $signed({{2{right_q[63]}}, right_q});
  assign dx = $signed({{2{dd_q[63]}}, dd_q});
  assign nx = $signed({{2{nn_q[63]}}, nn_q});
  assign ax = $signed({{34{an_q[31]}}, an_q});

  always_comb begin
    unique case (op_q)
      OpAdd: begin num_s = lx + rx; den_s = dx; end
      OpSub: begin num_s = lx - rx; den_s = dx; end
      OpMul: begin num_s = nx; den_s = dx; end
      OpDiv: begin num_s = lx; den_s = rx; end
      OpAbs: begin
        num_s = an_q[31] ? -ax : ax;
        den_s = $signed({{34{ad_q[31]}}, ad_q});
      end
      default: begin
        num_s = ax;
        den_s = $signed({{34{ad_q[31]}}, ad_q});
      end
    endcase
  end

  assign num_abs = num_s[65] ? 66'(-num_s) : 66'(num_s);
  assign den_abs = den_s[65] ? 66'(-den_s) : 66'(den_s);

  // gcd step
  logic [MagW-1:0] u_minus_v, v_minus_u;
  logic            u_ge_v;

  assign u_minus_v = u_q - v_q;
  assign v_minus_u = v_q - u_q;
  assign u_ge_v    = u_q >= v_q;

  // rounding
  logic r2ge, snap_hit, ovf;

  assign r2ge     = {r_q, 1'b0} >= {1'b0, d_q};
  assign snap_hit = (snap_q == '0) || (dist_q <= t_q);
  assign ovf      = (d_q > Lim) || (n_q > (rneg_q ? LimNeg : Lim));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_q <= 32'd65535;
    end else if (snap_inverse_we_i) begin
      snap_q <= snap_inverse_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q              <= StIdle;
      go_q                 <= 1'b0;
      done_q               <= 1'b0;
      result_numerator_o   <= '0;
      result_denominator_o <= 31'd1;
      a_less_o             <= 1'b0;
      a_greater_o          <= 1'b0;
      a_equal_o            <= 1'b0;
      status_o             <= StatOk;
    end else begin
      go_q   <= 1'b0;
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            op_q    <= opcode_i;
            an_q    <= a_numerator_i;
            ad_q    <= a_denominator_i;
            bn_q    <= b_numerator_i;
            bd_q    <= b_denominator_i;
            state_q <= StMulL;
          end
        end
        StMulL: begin
          left_q  <= prod[63:0];
          state_q <= StMulR;
        end
        StMulR: begin
          right_q <= prod[63:0];
          state_q <= StMulD;
        end
        StMulD: begin
          dd_q    <= prod[63:0];
          state_q <= StMulN;
        end
        StMulN: begin
          nn_q    <= prod[63:0];
          state_q <= StForm;
        end
        StForm: begin
          a_less_o    <= $signed(left_q) < $signed(right_q);
          a_greater_o <= $signed(left_q) > $signed(right_q);
          a_equal_o   <= (an_q == bn_q) && (ad_q == {1'b0, bd_q});
          num_neg_q   <= num_s[65];
          den_neg_q   <= den_s[65];
          num_q       <= num_abs[MagW-1:0];
          den_q       <= den_abs[MagW-1:0];
          u_q         <= num_abs[MagW-1:0];
          v_q         <= den_abs[MagW-1:0];
          k_q         <= '0;
          if (den_abs == '0) begin
            err_q   <= 1'b1;
            state_q <= StDone;
          end else begin
            err_q   <= 1'b0;
            state_q <= StGcd;
          end
        end
        StGcd: begin
          if (u_q == '0) begin
            g_q     <= v_q << k_q;
            dvd_q   <= num_q;
            dvs_q   <= v_q << k_q;
            go_q    <= 1'b1;
            state_q <= StDivN;
          end else if (!u_q[0] && !v_q[0]) begin
            u_q <= u_q >> 1;
            v_q <= v_q >> 1;
            k_q <= k_q + 1'b1;
          end else if (!u_q[0]) begin
            u_q <= u_q >> 1;
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
          end else if (u_ge_v) begin
            u_q <= u_minus_v >> 1;
          end else begin
            v_q <= v_minus_u >> 1;
          end
        end
        StDivN: begin
          if (div_res.done) begin
            n_q     <= div_res.quo;
            dvd_q   <= den_q;
            dvs_q   <= g_q;
            go_q    <= 1'b1;
            state_q <= StDivD;
          end
        end
        StDivD: begin
          if (div_res.done) begin
            d_q     <= div_res.quo;
            dvd_q   <= n_q;
            dvs_q   <= div_res.quo;
            go_q    <= 1'b1;
            state_q <= StDivQ;
          end
        end
        StDivQ: begin
          if (div_res.done) begin
            q_q <= div_res.quo;
            r_q <= div_res.rem;
            if (snap_q != '0) begin
              dvd_q   <= d_q;
              dvs_q   <= {32'd0, snap_q};
              go_q    <= 1'b1;
              state_q <= StDivS;
            end else begin
              state_q <= StRound;
            end
          end
        end
        StDivS: begin
          if (div_res.done) begin
            t_q     <= div_res.quo;
            state_q <= StRound;
          end
        end
        StRound: begin
          near_q  <= r2ge ? q_q + 64'd1 : q_q;
          dist_q  <= r2ge ? d_q - r_q : r_q;
          rneg_q  <= (num_neg_q != den_neg_q) && (n_q != '0);
          state_q <= StSnap;
        end
        StSnap: begin
          if (snap_hit) begin
            n_q <= near_q;
            d_q <= 64'd1;
            if (near_q == '0) begin
              rneg_q <= 1'b0;
            end
          end
          state_q <= StDone;
        end
        StDone: begin
          if (err_q) begin
            result_numerator_o   <= '0;
            result_denominator_o <= 31'd1;
            status_o             <= StatZero;
          end else if (ovf) begin
            result_numerator_o   <= '0;
            result_denominator_o <= 31'd1;
            status_o             <= StatWide;
          end else begin
            result_numerator_o   <= rneg_q ? -n_q[31:0] : n_q[31:0];
            result_denominator_o <= d_q[30:0];
            status_o             <= StatOk;
          end
          done_q  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result strobe outside end of item");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(a_less_o && a_greater_o))
    else $error("less and greater both set");

  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != StatOk |-> result_numerator_o == '0 && result_denominator_o == 31'd1)
    else $error("error result not zero over one");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == StDivN || state_q == StDivD || state_q == StDivQ
                     || state_q == StDivS)
    else $error("divider finished outside a divide step");

endmodule

### rtl/rau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rau_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::div_req_t req_i,
  output rau_pkg::div_res_t res_o
);
  import rau_pkg::*;

  localparam int unsigned CntW = $clog2(MagW);

  logic [CntW-1:0] cnt_q;
  logic            run_q;
  logic            done_q;
  logic [MagW-1:0] quo_q;
  logic [MagW-1:0] rem_q;
  logic [MagW-1:0] dvs_q;
  logic [MagW:0]   shifted;
  logic [MagW:0]   trial;

  assign shifted = {rem_q, quo_q[MagW-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        quo_q <= req_i.dividend;
        rem_q <= '0;
        dvs_q <= req_i.divisor;
      end else if (run_q) begin
        if (trial[MagW]) begin
          rem_q <= shifted[MagW-1:0];
          quo_q <= {quo_q[MagW-2:0], 1'b0};
        end else begin
          rem_q <= trial[MagW-1:0];
          quo_q <= {quo_q[MagW-2:0], 1'b1};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(MagW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o = '{done: done_q, quo: quo_q, rem: rem_q};

endmodule
